>>> sv/fdf_pkg.sv
`default_nettype none

package fdf_pkg;

    localparam int HDR_BYTES = 5;

    // input command codes (s_axis_tuser)
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // result kind codes (m_axis_tuser)
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // configuration register indexes
    localparam logic [2:0] REG_MARKER   = 3'd0;
    localparam logic [2:0] REG_MAX_LEN  = 3'd1;
    localparam logic [2:0] REG_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_CODES    = 3'd3;
    localparam logic [2:0] REG_VALID    = 3'd4;
    localparam logic [2:0] REG_CHANNELS = 3'd5;
    localparam logic [2:0] REG_PREFIX   = 3'd6;
    localparam logic [2:0] REG_DELIVER  = 3'd7;

    typedef enum logic [2:0] {
        ST_OK,
        ST_CRC,
        ST_HEADER,
        ST_LENGTH,
        ST_NO_CHAN,
        ST_TIMEOUT
    } t_status;

    typedef struct packed {
        logic [15:0] marker;
        logic [15:0] max_payload;
        logic [31:0] timeout;
        logic [63:0] code_table;
        logic [7:0]  entry_valid;
        logic [23:0] entry_channel;
        logic [7:0]  prefix_mask;
        logic [7:0]  deliver_mask;
    } t_cfg;

    typedef struct packed {
        logic       hit;
        logic [2:0] chan;
    } t_match;

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] v;
        v = crc ^ {d, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (v[15]) begin
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[14:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/fdf_lookup.sv
`default_nettype none

module fdf_lookup
    import fdf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8,
    parameter int CHANNELS      = 8
) (
    input  wire t_cfg   i_cfg,
    input  wire [7:0]   i_code,
    output t_match      o_match
);

    // walk from the top entry down so the lowest matching entry wins
    always_comb begin
        logic [2:0] ch;
        o_match = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            ch = i_cfg.entry_channel[3*i +: 3];
            if (i_cfg.entry_valid[i] && (i_cfg.code_table[8*i +: 8] == i_code)
                && ({1'b0, ch} < 4'(CHANNELS))) begin
                o_match.hit  = 1'b1;
                o_match.chan = ch;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/fdf_parser.sv
`default_nettype none

module fdf_parser
    import fdf_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire t_match i_match,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_in_cmd,
    input  wire [7:0]   i_in_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_out_chan,
    output t_status     o_out_status,
    output logic        o_out_last
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC
    } t_phase;

    localparam logic [2:0] HDR_LAST = 3'(HDR_BYTES - 1);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [7:0]  r_flag, n_flag;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic        r_crc_cnt, n_crc_cnt;
    logic [2:0]  r_chan, n_chan;
    logic [31:0] r_idle, n_idle;

    logic        r_out_valid;
    logic        r_out_kind, r_out_last;
    logic [7:0]  r_out_byte;
    logic [2:0]  r_out_chan;
    t_status     r_out_status;

    logic        accept;
    logic        emit, e_kind, e_last;
    logic [7:0]  e_byte;
    logic [2:0]  e_chan;
    t_status     e_status;
    logic [31:0] idle_inc;
    logic [15:0] left_dec;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign idle_inc   = (r_idle == '1) ? r_idle : r_idle + 32'd1;
    assign left_dec   = r_bytes_left - 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_flag       = r_flag;
        n_len_lo     = r_len_lo;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_crc_lo     = r_crc_lo;
        n_crc_cnt    = r_crc_cnt;
        n_chan       = r_chan;
        n_idle       = r_idle;
        emit         = 1'b0;
        e_kind       = KIND_BYTE;
        e_byte       = '0;
        e_chan       = '0;
        e_status     = ST_OK;
        e_last       = 1'b0;

        if (accept) begin
            if (i_in_cmd == CMD_TICK) begin
                if (r_phase != PH_WAIT) begin
                    n_idle = idle_inc;
                    if (idle_inc > i_cfg.timeout) begin
                        emit     = 1'b1;
                        e_kind   = KIND_STATUS;
                        e_chan   = r_chan;
                        e_status = ST_TIMEOUT;
                        e_last   = 1'b1;
                        n_phase      = PH_WAIT;
                        n_hdr_cnt    = '0;
                        n_bytes_left = '0;
                        n_crc_cnt    = 1'b0;
                        n_chan       = '0;
                        n_idle       = '0;
                    end
                end
            end else begin
                n_idle = '0;
                unique case (r_phase)
                    PH_WAIT: begin
                        if (i_in_byte == i_cfg.marker[7:0]) begin
                            n_crc     = crc_byte(CRC_INIT, i_in_byte);
                            n_hdr_cnt = 3'd1;
                            n_phase   = PH_HEADER;
                        end
                    end
                    PH_HEADER: begin
                        n_crc     = crc_byte(r_crc, i_in_byte);
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                        if (r_hdr_cnt == 3'd1) begin
                            n_flag = i_in_byte;
                        end
                        if (r_hdr_cnt == 3'd2) begin
                            n_len_lo = i_in_byte;
                        end
                        if (r_hdr_cnt == 3'd3) begin
                            n_bytes_left = {i_in_byte, r_len_lo};
                        end
                        if (r_hdr_cnt == HDR_LAST) begin
                            // code byte: run header checks, then table lookup
                            priority if (r_flag != i_cfg.marker[15:8]) begin
                                e_status = ST_HEADER;
                            end else if (r_bytes_left > i_cfg.max_payload) begin
                                e_status = ST_LENGTH;
                            end else if (!i_match.hit) begin
                                e_status = ST_NO_CHAN;
                            end else begin
                                e_status = ST_OK;
                            end
                            if (e_status != ST_OK) begin
                                emit         = 1'b1;
                                e_kind       = KIND_STATUS;
                                e_last       = 1'b1;
                                n_phase      = PH_WAIT;
                                n_hdr_cnt    = '0;
                                n_bytes_left = '0;
                                n_crc_cnt    = 1'b0;
                                n_chan       = '0;
                            end else begin
                                n_chan    = i_match.chan;
                                n_hdr_cnt = '0;
                                n_crc_cnt = 1'b0;
                                n_phase   = (r_bytes_left == '0) ? PH_CRC : PH_PAYLOAD;
                                if (i_cfg.prefix_mask[i_match.chan]
                                    && i_cfg.deliver_mask[i_match.chan]) begin
                                    emit   = 1'b1;
                                    e_byte = i_in_byte;
                                    e_chan = i_match.chan;
                                end
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_crc        = crc_byte(r_crc, i_in_byte);
                        n_bytes_left = left_dec;
                        if (left_dec == '0) begin
                            n_phase   = PH_CRC;
                            n_crc_cnt = 1'b0;
                        end
                        if (i_cfg.deliver_mask[r_chan]) begin
                            emit   = 1'b1;
                            e_byte = i_in_byte;
                            e_chan = r_chan;
                        end
                    end
                    PH_CRC: begin
                        if (!r_crc_cnt) begin
                            n_crc_lo  = i_in_byte;
                            n_crc_cnt = 1'b1;
                        end else begin
                            emit     = 1'b1;
                            e_kind   = KIND_STATUS;
                            e_chan   = r_chan;
                            e_status = ({i_in_byte, r_crc_lo} == r_crc) ? ST_OK : ST_CRC;
                            e_last   = 1'b1;
                            n_phase      = PH_WAIT;
                            n_hdr_cnt    = '0;
                            n_bytes_left = '0;
                            n_crc_cnt    = 1'b0;
                            n_chan       = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_hdr_cnt    <= '0;
            r_flag       <= '0;
            r_len_lo     <= '0;
            r_bytes_left <= '0;
            r_crc        <= CRC_INIT;
            r_crc_lo     <= '0;
            r_crc_cnt    <= 1'b0;
            r_chan       <= '0;
            r_idle       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_flag       <= n_flag;
            r_len_lo     <= n_len_lo;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_crc_lo     <= n_crc_lo;
            r_crc_cnt    <= n_crc_cnt;
            r_chan       <= n_chan;
            r_idle       <= n_idle;
            if (accept) begin
                r_out_valid <= emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_kind   <= e_kind;
            r_out_byte   <= e_byte;
            r_out_chan   <= e_chan;
            r_out_status <= e_status;
            r_out_last   <= e_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_byte   = r_out_byte;
    assign o_out_chan   = r_out_chan;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

    a_wait_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WAIT |-> r_idle == '0)
        else $error("idle counter running outside a frame");

    a_payload_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_left != '0)
        else $error("payload phase with no bytes left");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind == KIND_BYTE) |-> (r_out_status == ST_OK) && !r_out_last)
        else $error("payload result carries status fields");

    a_crc_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_cmd == CMD_BYTE) && (r_phase == PH_CRC) && r_crc_cnt
        |=> (r_phase == PH_WAIT) && r_out_valid && r_out_last)
        else $error("second CRC byte did not close the frame");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_out_valid)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire

>>> sv/frame_deframer_crc16.sv
// Frame deframer with CRC-16-CCITT check.
// Slave stream: s_axis_tuser = 0 carries a received byte in s_axis_tdata[7:0],
// s_axis_tuser = 1 is one time tick (tdata ignored).
// Master stream: m_axis_tuser = 0 is a payload byte, 1 a frame status; tlast
// marks the status that closes a frame. tdata holds byte, channel and status.
// Each input transaction's result is registered in the output register.
// Throughput: one input transaction per cycle while the output register is free or
// being taken; the whole step (byte CRC, header checks, eight-entry code compare)
// sits between the state registers and the single output register.
// Input transactions cause zero or one result. When the receiver stalls,
// the held result stays put and s_axis_tready drops until it is taken;
// a transaction with no result still needs the output register free.
// Reset (synchronous, active low) returns the parser to hunting for the start
// byte, drops any held result and restores register defaults.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index;
// write only while the block is idle.
`default_nettype none

module frame_deframer_crc16
    import fdf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8,
    parameter int CHANNELS      = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_index,
    input  wire [63:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // [7:0] rx_data
    input  wire         s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] channel,
                                        // [13:11] status_code, [15:14] zero
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // frame_last
);

    t_cfg    r_cfg;
    t_match  match;
    t_status out_status;
    logic [7:0] out_byte;
    logic [2:0] out_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marker        <= 16'h0000;
            r_cfg.max_payload   <= 16'd256;
            r_cfg.timeout       <= 32'd500;
            r_cfg.code_table    <= '0;
            r_cfg.entry_valid   <= '0;
            r_cfg.entry_channel <= '0;
            r_cfg.prefix_mask   <= '0;
            r_cfg.deliver_mask  <= 8'hFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MARKER:   r_cfg.marker        <= i_cfg_data[15:0];
                REG_MAX_LEN:  r_cfg.max_payload   <= i_cfg_data[15:0];
                REG_TIMEOUT:  r_cfg.timeout       <= i_cfg_data[31:0];
                REG_CODES:    r_cfg.code_table    <= i_cfg_data;
                REG_VALID:    r_cfg.entry_valid   <= i_cfg_data[7:0];
                REG_CHANNELS: r_cfg.entry_channel <= i_cfg_data[23:0];
                REG_PREFIX:   r_cfg.prefix_mask   <= i_cfg_data[7:0];
                REG_DELIVER:  r_cfg.deliver_mask  <= i_cfg_data[7:0];
            endcase
        end
    end

    fdf_lookup #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CHANNELS      (CHANNELS)
    ) u_lookup (
        .i_cfg   (r_cfg),
        .i_code  (s_axis_tdata),
        .o_match (match)
    );

    fdf_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_match      (match),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_cmd     (s_axis_tuser),
        .i_in_byte    (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_kind   (m_axis_tuser),
        .o_out_byte   (out_byte),
        .o_out_chan   (out_chan),
        .o_out_status (out_status),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_status, out_chan, out_byte};

endmodule

`default_nettype wire
